@@ hdl/mtr_pkg.sv @@
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared types and constants of the mosaic tile resampler: tile record
// layout, controller-to-datapath command word and status word.
// ----------------------------------------------------------------------------
package mtr_pkg;

	// Default configuration of the tile grid
	localparam int GRID_COLS_DEF    = 8;
	localparam int GRID_ROWS_DEF    = 8;
	localparam int MAX_TILE_DIM_DEF = 4096;

	// Number of tile slots held in storage
	localparam int SLOTS      = 64;
	localparam int SLOT_W     = 6;

	// Quotient bits kept by the divider; the top bit flags out-of-range
	localparam int QBITS      = 14;

	// Field widths
	localparam int OFF_W      = 32;
	localparam int COEF_W     = 21;
	localparam int DIM_W      = 13;
	localparam int PIX_W      = 16;
	localparam int SRC_W      = 12;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_RESOLVE = 1'b1
	} mtr_op_t;

	// One stored tile
	typedef struct packed {
		logic signed [OFF_W-1:0]  off_x;
		logic signed [OFF_W-1:0]  off_y;
		logic signed [COEF_W-1:0] sc_x;
		logic signed [COEF_W-1:0] sc_y;
		logic signed [COEF_W-1:0] sk_x;
		logic signed [COEF_W-1:0] sk_y;
		logic [DIM_W-1:0]         wid;
		logic [DIM_W-1:0]         hgt;
	} mtr_tile_t;

	localparam int TILE_W = $bits(mtr_tile_t);

	// Controller commands, one per datapath action
	typedef struct packed {
		logic load;     // store the incoming tile word
		logic capture;  // latch the pixel and clear the best candidate
		logic rd;       // read the current slot from tile memory
		logic fetch;    // offsets and determinant products
		logic mul;      // numerator products
		logic num;      // numerators
		logic prep;     // magnitudes and divider setup
		logic div;      // one restoring divide step
		logic eval;     // bounds check and candidate update
		logic emit;     // present the result
	} mtr_cmd_t;

	typedef struct packed {
		logic present;  // current slot holds a tile
	} mtr_sts_t;

endpackage

@@ hdl/mtr_ram.sv @@
// ----------------------------------------------------------------------------
// mtr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/mtr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtr_ctrl
// Sequencer of the resampler: walks the tile slots, steps each present
// tile through the transform stages and the divider, then emits the word.
// ----------------------------------------------------------------------------
module mtr_ctrl #(
	parameter int SCAN_N = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    operation,
	input  mtr_pkg::mtr_sts_t       sts,
	output logic                    busy,
	output mtr_pkg::mtr_cmd_t       cmd,
	output logic [mtr_pkg::SLOT_W-1:0] slot
);
	import mtr_pkg::*;

	localparam int CNT_W = $clog2(QBITS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_MUL,
		ST_NUM,
		ST_PREP,
		ST_DIV,
		ST_EVAL,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [SLOT_W:0]   slot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              scan_end;

	assign busy     = (state_q != ST_IDLE);
	assign slot     = slot_q[SLOT_W-1:0];
	assign scan_end = (slot_q == (SLOT_W+1)'(SCAN_N));

	// Decode commands from the state
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && start && (operation == OP_LOAD);
		cmd.capture = (state_q == ST_IDLE) && start && (operation == OP_RESOLVE);
		cmd.rd      = (state_q == ST_SCAN) && !scan_end && sts.present;
		cmd.fetch   = (state_q == ST_FETCH);
		cmd.mul     = (state_q == ST_MUL);
		cmd.num     = (state_q == ST_NUM);
		cmd.prep    = (state_q == ST_PREP);
		cmd.div     = (state_q == ST_DIV);
		cmd.eval    = (state_q == ST_EVAL);
		cmd.emit    = (state_q == ST_FINISH);
	end

	// Advance state, slot and divide step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						slot_q  <= '0;
						state_q <= (operation == OP_LOAD) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_FINISH;
					end else if (sts.present) begin
						state_q <= ST_FETCH;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				ST_FETCH: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_NUM;
				ST_NUM:   state_q <= ST_PREP;
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QBITS-1)) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					slot_q  <= slot_q + 1'b1;
					state_q <= ST_SCAN;
				end
				ST_FINISH: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/mtr_dp.sv @@
// ----------------------------------------------------------------------------
// mtr_dp
// Datapath of the resampler: tile storage and presence map, inverse affine
// transform, shared two-lane restoring divider and best-tile tracking.
// ----------------------------------------------------------------------------
module mtr_dp #(
	parameter int SCAN_N       = 64,
	parameter int MAX_TILE_DIM = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mtr_pkg::mtr_cmd_t                    cmd,
	input  logic [mtr_pkg::SLOT_W-1:0]           slot,
	output mtr_pkg::mtr_sts_t                    sts,
	input  logic [mtr_pkg::SLOT_W-1:0]           tile_slot,
	input  logic signed [mtr_pkg::OFF_W-1:0]     offset_x,
	input  logic signed [mtr_pkg::OFF_W-1:0]     offset_y,
	input  logic signed [mtr_pkg::COEF_W-1:0]    scale_x,
	input  logic signed [mtr_pkg::COEF_W-1:0]    scale_y,
	input  logic signed [mtr_pkg::COEF_W-1:0]    skew_x,
	input  logic signed [mtr_pkg::COEF_W-1:0]    skew_y,
	input  logic [mtr_pkg::DIM_W-1:0]            tile_width,
	input  logic [mtr_pkg::DIM_W-1:0]            tile_height,
	input  logic [mtr_pkg::PIX_W-1:0]            pixel_x,
	input  logic [mtr_pkg::PIX_W-1:0]            pixel_y,
	output logic                                 done,
	output logic                                 covered,
	output logic [mtr_pkg::SLOT_W-1:0]           winner_tile,
	output logic [mtr_pkg::SRC_W-1:0]            source_x,
	output logic [mtr_pkg::SRC_W-1:0]            source_y
);
	import mtr_pkg::*;

	localparam int D_W   = OFF_W + 2;            // pixel minus offset
	localparam int DET_W = 2 * COEF_W;           // determinant
	localparam int P_W   = D_W + COEF_W;         // numerator products
	localparam int N_W   = P_W + 1;              // numerator difference
	localparam int R_W   = N_W + 8 + 2;          // rounded dividend

	// Presence map
	logic [SLOTS-1:0] present_q;
	logic             slot_ok;
	mtr_tile_t        wtile, rtile;

	assign slot_ok     = (32'(tile_slot) < 32'(SCAN_N));
	assign sts.present = present_q[slot];

	// Clamp oversize dimensions and pack the tile word
	always_comb begin
		wtile.off_x = offset_x;
		wtile.off_y = offset_y;
		wtile.sc_x  = scale_x;
		wtile.sc_y  = scale_y;
		wtile.sk_x  = skew_x;
		wtile.sk_y  = skew_y;
		wtile.wid   = (32'(tile_width) > MAX_TILE_DIM) ? DIM_W'(MAX_TILE_DIM) : tile_width;
		wtile.hgt   = (32'(tile_height) > MAX_TILE_DIM) ? DIM_W'(MAX_TILE_DIM) : tile_height;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (cmd.load && slot_ok) begin
			present_q[tile_slot] <= 1'b1;
		end
	end

	mtr_ram #(
		.WIDTH (TILE_W),
		.DEPTH (SLOTS)
	) u_tiles (
		.clk   (clk),
		.we    (cmd.load && slot_ok),
		.waddr (tile_slot),
		.wdata (wtile),
		.re    (cmd.rd),
		.raddr (slot),
		.rdata (rtile)
	);

	// Pixel latch
	logic [PIX_W-1:0] pix_x_q, pix_y_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_x_q <= pixel_x;
			pix_y_q <= pixel_y;
		end
	end

	// Stage 1: offsets removed, determinant products
	logic signed [D_W-1:0]    dx_s1, dy_s1;
	logic signed [DET_W-1:0]  deta_s1, detb_s1;
	logic signed [COEF_W-1:0] sx_s1, sy_s1, kx_s1, ky_s1;
	logic [DIM_W-1:0]         w_s1, h_s1;
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			dx_s1   <= $signed({2'b00, pix_x_q, 8'h00}) - D_W'(rtile.off_x);
			dy_s1   <= $signed({2'b00, pix_y_q, 8'h00}) - D_W'(rtile.off_y);
			deta_s1 <= DET_W'(rtile.sc_y * rtile.sc_x);
			detb_s1 <= DET_W'(rtile.sk_y * rtile.sk_x);
			sx_s1   <= rtile.sc_x;
			sy_s1   <= rtile.sc_y;
			kx_s1   <= rtile.sk_x;
			ky_s1   <= rtile.sk_y;
			w_s1    <= rtile.wid;
			h_s1    <= rtile.hgt;
		end
	end

	// Stage 2: numerator products and determinant
	logic signed [P_W-1:0]   pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [DET_W-1:0] det_s2;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pa_s2  <= P_W'(dx_s1 * sy_s1);
			pb_s2  <= P_W'(dy_s1 * kx_s1);
			pc_s2  <= P_W'(dy_s1 * sx_s1);
			pd_s2  <= P_W'(dx_s1 * ky_s1);
			det_s2 <= deta_s1 - detb_s1;
		end
	end

	// Stage 3: numerators
	logic signed [N_W-1:0]   nu_s3, nv_s3;
	logic signed [DET_W-1:0] det_s3;
	always_ff @(posedge clk) begin
		if (cmd.num) begin
			nu_s3  <= N_W'(pa_s2) - N_W'(pb_s2);
			nv_s3  <= N_W'(pc_s2) - N_W'(pd_s2);
			det_s3 <= det_s2;
		end
	end

	// Magnitudes for round-half-away division: (2|n| + |d|) / (2|d|)
	logic [N_W-1:0]   mag_u, mag_v;
	logic [DET_W-1:0] mag_d;
	assign mag_u = nu_s3[N_W-1] ? N_W'(-nu_s3) : N_W'(nu_s3);
	assign mag_v = nv_s3[N_W-1] ? N_W'(-nv_s3) : N_W'(nv_s3);
	assign mag_d = det_s3[DET_W-1] ? DET_W'(-det_s3) : DET_W'(det_s3);

	// Shared restoring divider, one quotient bit a cycle for both lanes
	logic [R_W-1:0]   rem_u_q, rem_v_q, dsh_q;
	logic [QBITS-1:0] q_u_q, q_v_q;
	logic             neg_u_q, neg_v_q, detz_q;
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_u_q <= R_W'({mag_u, 9'h000}) + R_W'(mag_d);
			rem_v_q <= R_W'({mag_v, 9'h000}) + R_W'(mag_d);
			dsh_q   <= R_W'({mag_d, {QBITS{1'b0}}});
			q_u_q   <= '0;
			q_v_q   <= '0;
			neg_u_q <= nu_s3[N_W-1] ^ det_s3[DET_W-1];
			neg_v_q <= nv_s3[N_W-1] ^ det_s3[DET_W-1];
			detz_q  <= (det_s3 == '0);
		end else if (cmd.div) begin
			if (rem_u_q >= dsh_q) begin
				rem_u_q <= rem_u_q - dsh_q;
				q_u_q   <= {q_u_q[QBITS-2:0], 1'b1};
			end else begin
				q_u_q   <= {q_u_q[QBITS-2:0], 1'b0};
			end
			if (rem_v_q >= dsh_q) begin
				rem_v_q <= rem_v_q - dsh_q;
				q_v_q   <= {q_v_q[QBITS-2:0], 1'b1};
			end else begin
				q_v_q   <= {q_v_q[QBITS-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	// Bounds check and edge distance
	logic             hit;
	logic [DIM_W-1:0] du, dv, gap, dmin_x, dmin_y;
	logic [DIM_W-1:0] wu, hv;
	assign hit = !detz_q
		&& !(neg_u_q && (q_u_q != '0))
		&& !(neg_v_q && (q_v_q != '0))
		&& (q_u_q < QBITS'(w_s1))
		&& (q_v_q < QBITS'(h_s1));
	assign du     = DIM_W'(q_u_q);
	assign dv     = DIM_W'(q_v_q);
	assign wu     = w_s1 - du;
	assign hv     = h_s1 - dv;
	assign dmin_x = (wu < du) ? wu : du;
	assign dmin_y = (hv < dv) ? hv : dv;
	assign gap    = (dmin_y < dmin_x) ? dmin_y : dmin_x;

	// Track the best candidate; the earlier slot keeps a tie
	logic              found_q;
	logic [DIM_W-1:0]  best_q, bx_q, by_q;
	logic [SLOT_W-1:0] win_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.capture || cmd.load) begin
			found_q <= 1'b0;
		end else if (cmd.eval && hit && (!found_q || (gap > best_q))) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && hit && (!found_q || (gap > best_q))) begin
			best_q <= gap;
			win_q  <= slot;
			bx_q   <= du;
			by_q   <= dv;
		end
	end

	// Result word with its one-cycle strobe; the word holds until the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			covered     <= found_q;
			winner_tile <= found_q ? win_q : '0;
			source_x    <= found_q ? SRC_W'(bx_q) : '0;
			source_y    <= found_q ? SRC_W'(by_q) : '0;
		end
	end

endmodule

@@ hdl/mosaic_tile_resampler.sv @@
// A load returns its word through the finish state. A resolve scans the slots
// in order: a present tile steps through the fetch, multiply, numerator,
// prepare, divide and evaluate states, an empty slot is skipped, and the word
// then follows the finish state. One word at a time: busy stays high until
// the word is issued. Reset clears the presence map and all control state.
// The receiver cannot stall; the result strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
// mosaic_tile_resampler
// Inverse affine mosaic compositor: stores tile transforms and, for each
// output pixel, picks the covering tile farthest from its edge.
// ----------------------------------------------------------------------------
module mosaic_tile_resampler #(
	parameter int GRID_COLS    = mtr_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS    = mtr_pkg::GRID_ROWS_DEF,
	parameter int MAX_TILE_DIM = mtr_pkg::MAX_TILE_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 operation,
	input  logic [mtr_pkg::SLOT_W-1:0]           tile_slot,
	input  logic signed [mtr_pkg::OFF_W-1:0]     offset_x,
	input  logic signed [mtr_pkg::OFF_W-1:0]     offset_y,
	input  logic signed [mtr_pkg::COEF_W-1:0]    scale_x,
	input  logic signed [mtr_pkg::COEF_W-1:0]    scale_y,
	input  logic signed [mtr_pkg::COEF_W-1:0]    skew_x,
	input  logic signed [mtr_pkg::COEF_W-1:0]    skew_y,
	input  logic [mtr_pkg::DIM_W-1:0]            tile_width,
	input  logic [mtr_pkg::DIM_W-1:0]            tile_height,
	input  logic [mtr_pkg::PIX_W-1:0]            pixel_x,
	input  logic [mtr_pkg::PIX_W-1:0]            pixel_y,
	output logic                                 done,
	output logic                                 covered,
	output logic [mtr_pkg::SLOT_W-1:0]           winner_tile,
	output logic [mtr_pkg::SRC_W-1:0]            source_x,
	output logic [mtr_pkg::SRC_W-1:0]            source_y
);
	import mtr_pkg::*;

	localparam int SCAN_N = (GRID_COLS * GRID_ROWS < SLOTS) ? GRID_COLS * GRID_ROWS : SLOTS;

	mtr_cmd_t          cmd;
	mtr_sts_t          sts;
	logic [SLOT_W-1:0] slot;

	mtr_ctrl #(
		.SCAN_N (SCAN_N)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.busy      (busy),
		.cmd       (cmd),
		.slot      (slot)
	);

	mtr_dp #(
		.SCAN_N       (SCAN_N),
		.MAX_TILE_DIM (MAX_TILE_DIM)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.slot        (slot),
		.sts         (sts),
		.tile_slot   (tile_slot),
		.offset_x    (offset_x),
		.offset_y    (offset_y),
		.scale_x     (scale_x),
		.scale_y     (scale_y),
		.skew_x      (skew_x),
		.skew_y      (skew_y),
		.tile_width  (tile_width),
		.tile_height (tile_height),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.done        (done),
		.covered     (covered),
		.winner_tile (winner_tile),
		.source_x    (source_x),
		.source_y    (source_y)
	);

	// The word leaves only once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted word always engages the sequencer
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start work");

	// Exactly one word per item: no back-to-back strobes
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// A load never reports coverage
	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> ##1 (done && !covered))
		else $error("load result not cleared");

endmodule

@@ tb/mosaic_tile_resampler_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mosaic_tile_resampler_test
// Drives tile loads and pixel resolves into the resampler and checks every
// result word against an inverse-affine predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module mosaic_tile_resampler_test;
	import mtr_pkg::*;

	localparam int PERIOD    = 12;
	localparam int CYC_LIMIT = 6000000;
	localparam int RAND_WORDS = 850;
	localparam int GRID_N    = GRID_COLS_DEF * GRID_ROWS_DEF;

	typedef struct {
		mtr_op_t             op;
		logic [SLOT_W-1:0]   slot;
		logic [OFF_W-1:0]    ox, oy;
		logic [COEF_W-1:0]   scx, scy, skx, sky;
		logic [DIM_W-1:0]    wid, hgt;
		logic [PIX_W-1:0]    px, py;
	} word_t;

	typedef struct {
		logic              cov;
		logic [SLOT_W-1:0] win;
		logic [SRC_W-1:0]  sx, sy;
	} answer_t;

	// Tile store, coverage predictor and queue of pending answers
	class tile_scoreboard;
		bit      present[SLOTS];
		longint  off_x[SLOTS], off_y[SLOTS];
		longint  sc_x[SLOTS], sc_y[SLOTS], sk_x[SLOTS], sk_y[SLOTS];
		longint  wid[SLOTS], hgt[SLOTS];
		answer_t pending[$];
		int      errors, loads, resolves, hits;

		function new();
			for (int s = 0; s < SLOTS; s++) present[s] = 0;
			errors = 0; loads = 0; resolves = 0; hits = 0;
		endfunction

		// Divide rounding half away from zero; returns magnitude
		function longint unsigned div_round(longint n, longint d, output bit neg);
			longint unsigned un, ud, q;
			un = n < 0 ? longint'(-n) : n;
			ud = d < 0 ? longint'(-d) : d;
			q = (2 * un + ud) / (2 * ud);
			neg = ((n < 0) != (d < 0)) && q != 0;
			return q;
		endfunction

		function longint clamp_dim(logic [DIM_W-1:0] v);
			return v > MAX_TILE_DIM_DEF ? longint'(MAX_TILE_DIM_DEF) : longint'(v);
		endfunction

		function answer_t resolve_pixel(word_t w);
			answer_t a;
			longint  best, det, dx, dy, gap;
			longint unsigned u, v;
			bit nu, nv;
			a = '{cov: 0, win: 0, sx: 0, sy: 0};
			best = -1;
			for (int s = 0; s < GRID_N && s < SLOTS; s++) begin
				if (!present[s]) continue;
				det = sc_y[s] * sc_x[s] - sk_y[s] * sk_x[s];
				if (det == 0) continue;
				dx = longint'(w.px) * 256 - off_x[s];
				dy = longint'(w.py) * 256 - off_y[s];
				u = div_round((dx * sc_y[s] - dy * sk_x[s]) * 256, det, nu);
				v = div_round((dy * sc_x[s] - dx * sk_y[s]) * 256, det, nv);
				if (nu || nv || u >= wid[s] || v >= hgt[s]) continue;
				gap = u;
				if (wid[s] - longint'(u) < gap) gap = wid[s] - longint'(u);
				if (longint'(v) < gap) gap = v;
				if (hgt[s] - longint'(v) < gap) gap = hgt[s] - longint'(v);
				if (gap > best) begin
					best = gap;
					a.cov = 1;
					a.win = SLOT_W'(s);
					a.sx = u[SRC_W-1:0];
					a.sy = v[SRC_W-1:0];
				end
			end
			return a;
		endfunction

		// Note an accepted word: update the store and queue its answer
		function void note_word(word_t w);
			answer_t a;
			a = '{cov: 0, win: 0, sx: 0, sy: 0};
			if (w.op == OP_LOAD) begin
				loads++;
				if (w.slot < GRID_N) begin
					present[w.slot] = 1;
					off_x[w.slot] = signed'(w.ox);
					off_y[w.slot] = signed'(w.oy);
					sc_x[w.slot] = signed'(w.scx);
					sc_y[w.slot] = signed'(w.scy);
					sk_x[w.slot] = signed'(w.skx);
					sk_y[w.slot] = signed'(w.sky);
					wid[w.slot] = clamp_dim(w.wid);
					hgt[w.slot] = clamp_dim(w.hgt);
				end
			end else begin
				resolves++;
				a = resolve_pixel(w);
				if (a.cov) hits++;
			end
			pending.push_back(a);
		endfunction

		// Compare a result word with the oldest pending answer
		function void check_word(answer_t got);
			answer_t exp_a;
			if (pending.size() == 0) begin
				$error("result word with nothing pending");
				errors++;
				return;
			end
			exp_a = pending.pop_front();
			if (got.cov !== exp_a.cov) begin
				$error("covered: expected %0d, got %0d", exp_a.cov, got.cov);
				errors++;
			end
			if (got.win !== exp_a.win) begin
				$error("winner_tile: expected %0d, got %0d", exp_a.win, got.win);
				errors++;
			end
			if (got.sx !== exp_a.sx) begin
				$error("source_x: expected %0d, got %0d", exp_a.sx, got.sx);
				errors++;
			end
			if (got.sy !== exp_a.sy) begin
				$error("source_y: expected %0d, got %0d", exp_a.sy, got.sy);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0;
	logic busy, done, covered;
	logic operation = 0;
	logic [SLOT_W-1:0] tile_slot = 0;
	logic signed [OFF_W-1:0] offset_x = 0, offset_y = 0;
	logic signed [COEF_W-1:0] scale_x = 0, scale_y = 0, skew_x = 0, skew_y = 0;
	logic [DIM_W-1:0] tile_width = 0, tile_height = 0;
	logic [PIX_W-1:0] pixel_x = 0, pixel_y = 0;
	logic [SLOT_W-1:0] winner_tile;
	logic [SRC_W-1:0] source_x, source_y;

	tile_scoreboard sb = new();
	int idle_pct = 0;
	int cycles = 0;

	mosaic_tile_resampler dut (.*);

	always #(PERIOD / 2) clk = ~clk;

	// Watch the result strobe
	always @(posedge clk) begin
		if (done) sb.check_word('{cov: covered, win: winner_tile, sx: source_x, sy: source_y});
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Present one word and hold it until accepted; leaves start high
	task automatic send_word(word_t w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		operation <= w.op;
		tile_slot <= w.slot;
		offset_x <= w.ox; offset_y <= w.oy;
		scale_x <= w.scx; scale_y <= w.scy;
		skew_x <= w.skx; skew_y <= w.sky;
		tile_width <= w.wid; tile_height <= w.hgt;
		pixel_x <= w.px; pixel_y <= w.py;
		do @(posedge clk); while (busy);
		sb.note_word(w);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic word_t load_word(int slot, int ox, int oy, int scx, int scy,
			int skx, int sky, int w, int h);
		word_t r;
		r = '{op: OP_LOAD, slot: SLOT_W'(slot), ox: OFF_W'(ox), oy: OFF_W'(oy),
			scx: COEF_W'(scx), scy: COEF_W'(scy), skx: COEF_W'(skx), sky: COEF_W'(sky),
			wid: DIM_W'(w), hgt: DIM_W'(h), px: PIX_W'($urandom), py: PIX_W'($urandom)};
		return r;
	endfunction

	function automatic word_t pixel_word(int x, int y);
		word_t r;
		r = '{op: OP_RESOLVE, slot: SLOT_W'($urandom), ox: OFF_W'($urandom),
			oy: OFF_W'($urandom), scx: COEF_W'($urandom), scy: COEF_W'($urandom),
			skx: COEF_W'($urandom), sky: COEF_W'($urandom), wid: DIM_W'($urandom),
			hgt: DIM_W'($urandom), px: PIX_W'(x), py: PIX_W'(y)};
		return r;
	endfunction

	// Well-formed tile near its grid cell: near-unity scale, small skew
	function automatic word_t mosaic_tile();
		int s, c, r;
		s = $urandom_range(GRID_N - 1);
		c = s % GRID_COLS_DEF;
		r = s / GRID_COLS_DEF;
		return load_word(s, (c * 32 + $urandom_range(8)) * 256 + $urandom_range(255),
			(r * 32 + $urandom_range(8)) * 256 + $urandom_range(255),
			65536 + $urandom_range(8000) - 4000, 65536 + $urandom_range(8000) - 4000,
			$urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
			$urandom_range(48, 8), $urandom_range(48, 8));
	endfunction

	function automatic word_t noise_word();
		word_t r;
		r = pixel_word($urandom, $urandom);
		if ($urandom_range(1)) r.op = OP_LOAD;
		return r;
	endfunction

	initial begin
		word_t w;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: identity tile, extremes, rounding, ties, degenerate tiles
		send_word(pixel_word(0, 0));
		send_word(load_word(0, 0, 0, 65536, 65536, 0, 0, 16, 16));
		send_word(pixel_word(0, 0));
		send_word(pixel_word(15, 15));
		send_word(pixel_word(16, 3));
		send_word(load_word(1, 0, 0, 65536, 65536, 0, 0, 16, 16));
		send_word(pixel_word(8, 8));
		send_word(load_word(2, 0, 0, 131072, 131072, 0, 0, 64, 64));
		send_word(pixel_word(9, 7));
		send_word(load_word(3, 'h7FFFFFFF, 'h80000000, -1048576, 1048575, 1048575, -1048576,
			4096, 4096));
		send_word(load_word(5, 0, 0, 0, 0, 0, 0, 100, 100));
		send_word(load_word(6, 0, 0, 65536, 65536, 0, 0, 0, 10));
		send_word(load_word(7, 100, 100, 65536, 65536, 0, 0, 8191, 5000));
		send_word(pixel_word(65535, 65535));
		send_word(pixel_word(4000, 4000));
		send_word(load_word(0, 4 * 256, 4 * 256, 65536, 65536, 0, 0, 16, 16));
		send_word(pixel_word(2, 2));
		send_word(pixel_word(10, 11));
		send_word(load_word(8, 'hFFFFFF80, 0, 65536, 65536, 0, 0, 8, 8));
		send_word(pixel_word(0, 0));
		drain();

		// Random: three idling phases; mostly pixel resolves, some mosaic tiles and noise
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = ph == 0 ? 8 : ph == 1 ? 88 : 0;
			for (int i = 0; i < RAND_WORDS / 3; i++) begin
				case ($urandom_range(9))
					0: w = noise_word();
					1, 2: w = mosaic_tile();
					default: w = pixel_word($urandom_range(300), $urandom_range(300));
				endcase
				send_word(w);
				if (i == 40) drain();
			end
		end
		drain();
		repeat (1400) @(posedge clk);

		$display("%0d loads, %0d resolves, %0d covered pixels checked",
			sb.loads, sb.resolves, sb.hits);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
